>>> rtl/sorted_id_binary_search_core_assert.svh
// ----------------------------------------------------------------------------
// Sorted ID binary search - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_ID_BINARY_SEARCH_CORE_ASSERT_SVH
`define SORTED_ID_BINARY_SEARCH_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SIBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sibs assertion failed");

// consequent checked in the cycle after the antecedent
`define SIBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sibs assertion failed");

`endif

>>> rtl/sibs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted ID binary search - package
// Table geometry, field widths, operation codes and controller interfaces.
// ----------------------------------------------------------------------------
package sibs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // signed search bounds: first in [0, depth], last in [-1, depth - 1]
    localparam int PTR_W       = $clog2(TABLE_DEPTH + 1) + 1;
    localparam int KEY_W       = 32;
    localparam int SLOT_W      = 8;
    localparam int POS_W       = 8;
    localparam int CNT_W       = 9;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_SEARCH = 1'b1
    } t_func;

    typedef struct packed {
        logic load;      // start a search: capture key, open full range
        logic wr;        // store key at slot
        logic rd_en;     // issue table read at the current midpoint
        logic step;      // narrow the range from the last probe
        logic set_hit;   // record found at the probed index
        logic set_miss;  // record not found
        logic out_load;  // move recorded result into the output register
    } t_cmd;

    typedef struct packed {
        logic empty;       // current range is empty
        logic empty_step;  // range narrowed by the last probe is empty
        logic hit;         // probed entry equals the key
    } t_stat;

endpackage

>>> rtl/sibs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sibs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/sibs_datapath.sv
// ----------------------------------------------------------------------------
// Sorted ID binary search - datapath
// ID table, search bounds, probe compare, count register and result registers.
// ----------------------------------------------------------------------------
`include "sorted_id_binary_search_core_assert.svh"

module sibs_datapath import sibs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_cfg_valid,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_found,
    output logic [POS_W-1:0]  o_position
);

    logic [CNT_W-1:0]        r_count;
    logic [KEY_W-1:0]        r_key;
    logic signed [PTR_W-1:0] r_first;
    logic signed [PTR_W-1:0] r_last;
    logic [ADDR_W-1:0]       r_mid;
    logic                    r_res_found;
    logic [POS_W-1:0]        r_res_pos;
    logic                    r_out_found;
    logic [POS_W-1:0]        r_out_pos;

    logic signed [PTR_W-1:0] w_n;
    logic signed [PTR_W-1:0] w_mid_ext;
    logic signed [PTR_W-1:0] w_step_first;
    logic signed [PTR_W-1:0] w_step_last;
    logic signed [PTR_W-1:0] w_first;
    logic signed [PTR_W-1:0] w_last;
    logic signed [PTR_W:0]   w_sum;
    logic [ADDR_W-1:0]       w_rd_addr;
    logic [KEY_W-1:0]        w_rd_data;
    logic                    w_wr_en;
    logic                    w_hit;

    // clamp the searched count to the table depth
    always_comb begin
        if (32'(r_count) > 32'(TABLE_DEPTH)) begin
            w_n = PTR_W'(TABLE_DEPTH);
        end else begin
            w_n = PTR_W'(r_count);
        end
    end

    assign w_mid_ext = PTR_W'(r_mid);
    assign w_hit     = (w_rd_data == r_key);

    // range narrowed by the probe that just returned
    always_comb begin
        w_step_first = r_first;
        w_step_last  = r_last;
        if (w_rd_data <= r_key) begin
            w_step_first = w_mid_ext + PTR_W'(1);
        end else begin
            w_step_last = w_mid_ext - PTR_W'(1);
        end
    end

    assign w_first = i_cmd.step ? w_step_first : r_first;
    assign w_last  = i_cmd.step ? w_step_last : r_last;

    // sum is never negative while the range is open, so the shift truncates correctly
    assign w_sum     = (PTR_W + 1)'(w_first) + (PTR_W + 1)'(w_last);
    assign w_rd_addr = w_sum[ADDR_W:1];

    assign o_stat.empty      = (r_first > r_last);
    assign o_stat.empty_step = (w_step_first > w_step_last);
    assign o_stat.hit        = w_hit;

    assign w_wr_en = i_cmd.wr && (32'(i_slot) < 32'(TABLE_DEPTH));

    sibs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (ADDR_W'(i_slot)),
        .i_wr_data (i_key),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_key;
            r_first <= '0;
            r_last  <= w_n - PTR_W'(1);
        end else begin
            r_first <= w_first;
            r_last  <= w_last;
        end
        if (i_cmd.rd_en) begin
            r_mid <= w_rd_addr;
        end
        if (i_cmd.set_hit) begin
            r_res_found <= 1'b1;
            r_res_pos   <= POS_W'(r_mid);
        end else if (i_cmd.set_miss) begin
            r_res_found <= 1'b0;
            r_res_pos   <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_res_found;
            r_out_pos   <= r_res_pos;
        end
    end

    assign o_found    = r_out_found;
    assign o_position = r_out_pos;

    `SIBS_ASSERT_NEXT(a_mid_in_range, i_clk, i_rst_n, i_cmd.rd_en,
        (w_mid_ext >= r_first) && (w_mid_ext <= r_last))
    `SIBS_ASSERT_NEXT(a_miss_pos_zero, i_clk, i_rst_n, i_cmd.out_load,
        r_out_found || (r_out_pos == '0))
    `SIBS_ASSERT_SAME(a_hit_matches, i_clk, i_rst_n, i_cmd.set_hit, w_hit)

endmodule

>>> rtl/sibs_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted ID binary search - controller
// Sequences table writes and search probes, owns the item handshakes.
// ----------------------------------------------------------------------------
`include "sorted_id_binary_search_core_assert.svh"

module sibs_ctrl import sibs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_func,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_CMP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_in_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (t_func'(i_func) == FUNC_SEARCH) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_ISSUE;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_ISSUE: begin
                if (i_stat.empty) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.hit) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    // narrow and probe again, or drop out when the range closes
                    o_cmd.step = 1'b1;
                    if (i_stat.empty_step) begin
                        o_cmd.set_miss = 1'b1;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                    end
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `SIBS_ASSERT_SAME(a_read_in_search, i_clk, i_rst_n, o_cmd.rd_en,
        (r_state == S_ISSUE) || (r_state == S_CMP))
    `SIBS_ASSERT_SAME(a_no_wr_during_read, i_clk, i_rst_n, o_cmd.wr,
        !o_cmd.rd_en && !o_cmd.step)
    `SIBS_ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n, o_cmd.out_load,
        r_out_valid && (r_state == S_IDLE))

endmodule

>>> rtl/sorted_id_binary_search_core.sv
// ----------------------------------------------------------------------------
// Sorted ID binary search core
// Table of sorted 32-bit identifiers with write and binary-search items.
// ----------------------------------------------------------------------------
// A write item (func 0) stores key at slot and gives no result; the core is
// ready again on the next cycle. A search item (func 1) looks for key among
// the first entry_count entries (capped at the table depth) and gives one
// result: found and position. Each probe is one registered read of the table
// RAM, so a search takes up to ceil(log2(count+1)) probes, about 9 for a full
// 256-entry table, plus an accept, a setup step and a result step. The result
// waits in an output register, so writes and the next search are accepted
// while it is still pending. entry_count is written through the config
// channel, which is always ready, and must change only while the core is idle.
// ----------------------------------------------------------------------------
module sorted_id_binary_search_core import sibs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_found,
    output logic [POS_W-1:0]  o_position
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    sibs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    sibs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_slot      (i_slot),
        .i_key       (i_key),
        .o_found     (o_found),
        .o_position  (o_position)
    );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Sorted ID binary search core - testbench
// Fills the identifier table with sorted runs, sets entry_count over its full
// range and searches for present, neighboring and random keys. A scoreboard
// predicts each lookup and compares it field by field with the core's result,
// while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sibs_pkg::*;

    localparam int ITEM_TARGET  = 1450;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } lookup_t;

    class id_table_scoreboard;
        logic [KEY_W-1:0] ids [TABLE_DEPTH];
        logic [CNT_W-1:0] entry_count;
        lookup_t          pending_lookups [$];
        int               errors;
        int               writes;
        int               searches;
        int               hits;

        function new();
            entry_count = '0;
            errors      = 0;
            writes      = 0;
            searches    = 0;
            hits        = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] value);
            entry_count = value;
        endfunction

        function int pending();
            return pending_lookups.size();
        endfunction

        function lookup_t binary_lookup(logic [KEY_W-1:0] key);
            lookup_t r;
            int      n;
            int      lo;
            int      hi;
            int      mid;
            r  = '0;
            n  = int'(entry_count);
            if (n > TABLE_DEPTH) begin
                n = TABLE_DEPTH;
            end
            lo = 0;
            hi = n - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (ids[mid] == key) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(mid);
                    return r;
                end
                if (ids[mid] < key) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            return r;
        endfunction

        function void note_input(t_func func, logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] key);
            lookup_t r;
            if (func == FUNC_WRITE) begin
                ids[slot] = key;
                writes++;
            end else begin
                r = binary_lookup(key);
                pending_lookups.push_back(r);
                searches++;
                if (r.found) begin
                    hits++;
                end
            end
        endfunction

        function void check_result(logic found, logic [POS_W-1:0] position);
            lookup_t want;
            if (pending_lookups.size() == 0) begin
                $error("unexpected result: found %0d position %0d", found, position);
                errors++;
                return;
            end
            want = pending_lookups.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, found);
                errors++;
            end
            if (position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, position);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic              i_func      = FUNC_WRITE;
    logic [SLOT_W-1:0] i_slot      = '0;
    logic [KEY_W-1:0]  i_key       = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_found;
    logic [POS_W-1:0]  o_position;

    id_table_scoreboard sb = new();

    int       items_sent = 0;
    int       cfg_writes = 0;
    int       burst_left = 0;
    bit       gaps_on    = 1'b0;
    int       stall_left = 0;
    int       stall_mode = 0;
    bit [7:0] stall_mask = 8'h01;

    sorted_id_binary_search_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_slot      (i_slot),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found),
        .o_position  (o_position)
    );

    always #5 i_clk = ~i_clk;

    // Check accepted results, then pick the ready level for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_found, o_position);
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 160);
            stall_mask = 8'($urandom) | 8'h01;
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                i_out_ready <= stall_mask[0];
                stall_mask = {stall_mask[0], stall_mask[7:1]};
            end
        endcase
    end

    // Send one item; gaps, when enabled, fall between bursts of random length.
    task automatic issue(input t_func func, input logic [SLOT_W-1:0] slot,
                         input logic [KEY_W-1:0] key);
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_slot     <= slot;
        i_key      <= key;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(func, slot, key);
        items_sent++;
    endtask

    task automatic search(input logic [KEY_W-1:0] key);
        issue(FUNC_SEARCH, SLOT_W'($urandom), key);
    endtask

    // Hold input until every lookup has returned, then let the core settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_entry_count(input logic [CNT_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_count(value);
        cfg_writes++;
    endtask

    // Write an ascending run into slots 0..n-1; a dense run repeats values.
    task automatic fill_sorted(input int n);
        logic [32:0] acc;
        logic [31:0] span;
        int          i;
        if (n == 0) begin
            return;
        end
        span = ($urandom_range(0, 2) == 0) ? 32'd3 : 32'hFFFF_FFFF / n;
        acc  = ($urandom_range(0, 3) == 0) ? 33'd0 : 33'($urandom_range(0, span));
        for (i = 0; i < n; i++) begin
            issue(FUNC_WRITE, SLOT_W'(i), acc[31:0]);
            acc = acc + $urandom_range(0, span) + $urandom_range(0, span);
            if (acc > 33'hFFFF_FFFF) begin
                acc = 33'hFFFF_FFFF;
            end
        end
    endtask

    initial begin : watchdog
        #5_000_000;
        $display("** sorted_id_binary_search_core: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [KEY_W-1:0] directed_ids [8];
        logic [KEY_W-1:0] k;
        int               phase;
        int               cnt;
        int               n;
        int               filled_len;
        int               r;
        int               i;

        directed_ids = '{32'h0000_0000, 32'h0000_0003, 32'h0000_0064, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'hDEAD_BEEF, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Count zero out of reset: nothing is probed.
        search(32'h0000_0000);
        search(32'hFFFF_FFFF);
        for (i = 0; i < 8; i++) begin
            issue(FUNC_WRITE, SLOT_W'(i), directed_ids[i]);
        end
        issue(FUNC_WRITE, 8'hFF, 32'hA5A5_A5A5);
        filled_len = 8;

        set_entry_count(9'd8);
        search(32'h0000_0000);
        search(32'hFFFF_FFFF);
        search(32'h8000_0000);
        search(32'h0000_0064);
        search(32'h0000_0032);
        search(32'hFFFF_FFFD);

        set_entry_count(9'd1);
        search(32'h0000_0000);
        search(32'h0000_0003);

        // Break the order: the probe path no longer reaches slot 1.
        set_entry_count(9'd8);
        issue(FUNC_WRITE, 8'd3, 32'h0000_0001);
        search(32'h0000_0001);
        search(32'h0000_0003);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: cnt = 511;
                1: cnt = 256;
                2: cnt = 0;
                default: begin
                    r = $urandom_range(0, 29);
                    if (r == 0) begin
                        cnt = 0;
                    end else if (r == 1) begin
                        cnt = 1;
                    end else if (r == 2) begin
                        cnt = 256;
                    end else if (r == 3) begin
                        cnt = $urandom_range(257, 511);
                    end else if (r < 10) begin
                        cnt = $urandom_range(2, 255);
                    end else begin
                        cnt = $urandom_range(2, 32);
                    end
                end
            endcase
            n = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
            gaps_on = ($urandom_range(0, 3) != 0);
            set_entry_count(CNT_W'(cnt));
            if (n > filled_len || $urandom_range(0, 3) != 0) begin
                fill_sorted(n);
                if (n > filled_len) begin
                    filled_len = n;
                end
            end

            repeat ($urandom_range(15, 45)) begin
                r = $urandom_range(0, 19);
                if (n > 0) begin
                    k = sb.ids[$urandom_range(0, n - 1)];
                end else begin
                    k = $urandom;
                end
                if (r == 0) begin
                    // stray write: may land inside the run and unsort it
                    issue(FUNC_WRITE, SLOT_W'($urandom), $urandom);
                end else if (r < 10) begin
                    search(k);
                end else if (r < 12) begin
                    search(k + 1);
                end else if (r < 14) begin
                    search(k - 1);
                end else if (r == 14) begin
                    search(32'h0000_0000);
                end else if (r == 15) begin
                    search(32'hFFFF_FFFF);
                end else begin
                    search($urandom);
                end
            end
            phase++;
        end

        drain_results();
        $display("%0d searches (%0d hits), %0d table writes, %0d entry_count writes",
                 sb.searches, sb.hits, sb.writes, cfg_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** sorted_id_binary_search_core: PASSED **");
        end else begin
            $display("** sorted_id_binary_search_core: FAILED **");
        end
        $finish;
    end
endmodule
